// ===== sv/bcu_pkg.sv =====
// Shared types, widths and controller encodings for the binomial coefficient unit.
package bcu_pkg;

  localparam int RESULT_WIDTH    = 64;
  localparam int INDEX_WIDTH     = 16;
  localparam int FIELD_WIDTH     = 16;
  localparam int COEFF_WIDTH     = 64;
  localparam int WORK_WIDTH      = INDEX_WIDTH - 1;
  localparam int LO_WIDTH        = RESULT_WIDTH / 2;
  localparam int HI_WIDTH        = RESULT_WIDTH - LO_WIDTH;
  localparam int PROD_WIDTH      = RESULT_WIDTH + WORK_WIDTH;
  localparam int REM_WIDTH       = WORK_WIDTH + 1;
  localparam int DIV_COUNT_WIDTH = $clog2(PROD_WIDTH);

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] n_value;
    logic signed [FIELD_WIDTH-1:0] k_value;
  } bcu_req_t;

  typedef struct packed {
    logic [COEFF_WIDTH-1:0] coefficient;
    logic                   domain_error;
    logic                   overflow;
  } bcu_result_t;

  typedef struct packed {
    logic idle;
    logic load;
    logic mul_lo;
    logic mul_hi;
    logic div_step;
    logic commit;
    logic emit;
  } bcu_cmd_t;

  typedef struct packed {
    logic loop_done;
  } bcu_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOP_TEST,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIV,
    ST_COMMIT,
    ST_FINISH
  } bcu_state_t;

endpackage

// ===== sv/bcu_ctrl.sv =====
// Sequencer for the multiply / divide loop of the binomial coefficient unit.
module bcu_ctrl
  import bcu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        out_free,
  input  bcu_status_t status,
  output bcu_cmd_t    cmd
);

  bcu_state_t                 state;
  bcu_state_t                 state_next;
  logic [DIV_COUNT_WIDTH-1:0] bit_count;
  logic                       div_last;

  assign div_last = (bit_count == DIV_COUNT_WIDTH'(PROD_WIDTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      bit_count <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DIV) begin
        bit_count <= bit_count + 1'b1;
      end else begin
        bit_count <= '0;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_LOOP_TEST;
      end
      ST_LOOP_TEST: begin
        state_next = status.loop_done ? ST_FINISH : ST_MUL_LO;
      end
      ST_MUL_LO:  state_next = ST_MUL_HI;
      ST_MUL_HI:  state_next = ST_DIV;
      ST_DIV: begin
        if (div_last) state_next = ST_COMMIT;
      end
      ST_COMMIT:  state_next = ST_LOOP_TEST;
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.idle = 1'b1;
        cmd.load = in_valid;
      end
      ST_MUL_LO:  cmd.mul_lo   = 1'b1;
      ST_MUL_HI:  cmd.mul_hi   = 1'b1;
      ST_DIV:     cmd.div_step = 1'b1;
      ST_COMMIT:  cmd.commit   = 1'b1;
      ST_FINISH:  cmd.emit     = out_free;
      default:    cmd          = '0;
    endcase
  end

endmodule

// ===== sv/bcu_datapath.sv =====
// Operand registers, shared 32-bit multiplier and restoring divider.
module bcu_datapath
  import bcu_pkg::*;
(
  input  logic        clk,
  input  bcu_cmd_t    cmd,
  input  bcu_req_t    req,
  output bcu_status_t status,
  output bcu_result_t result
);

  logic [RESULT_WIDTH-1:0] accumulator;
  logic [WORK_WIDTH-1:0]   step_index;
  logic [WORK_WIDTH-1:0]   work_n;
  logic [WORK_WIDTH-1:0]   work_k;
  logic [REM_WIDTH-1:0]    rem;
  logic [PROD_WIDTH-1:0]   quo;
  logic                    dom_err;
  logic                    ovf;

  // Request decode
  logic signed [INDEX_WIDTH-1:0] n_s;
  logic signed [INDEX_WIDTH-1:0] k_s;
  logic signed [INDEX_WIDTH-1:0] k_red;
  logic                          dom;

  assign n_s   = req.n_value[INDEX_WIDTH-1:0];
  assign k_s   = req.k_value[INDEX_WIDTH-1:0];
  assign dom   = (n_s < 0) || (k_s < 0) || (k_s > n_s);
  assign k_red = (k_s > (n_s >>> 1)) ? (n_s - k_s) : k_s;

  // Shared multiplier: one half of the accumulator times (n - i)
  logic [WORK_WIDTH-1:0]          multiplier;
  logic [HI_WIDTH-1:0]            mul_operand;
  logic [HI_WIDTH+WORK_WIDTH-1:0] product;

  assign multiplier  = work_n - step_index;
  assign mul_operand = cmd.mul_hi ? accumulator[RESULT_WIDTH-1:LO_WIDTH]
                                  : HI_WIDTH'(accumulator[LO_WIDTH-1:0]);
  assign product     = mul_operand * multiplier;

  // One restoring divide step by (i + 1)
  logic [WORK_WIDTH-1:0] divisor;
  logic [REM_WIDTH-1:0]  rem_sh;
  logic [REM_WIDTH:0]    trial;

  assign divisor = step_index + 1'b1;
  assign rem_sh  = {rem[REM_WIDTH-2:0], quo[PROD_WIDTH-1]};
  assign trial   = {1'b0, rem_sh} - (REM_WIDTH + 1)'(divisor);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work_n      <= n_s[WORK_WIDTH-1:0];
      work_k      <= dom ? '0 : k_red[WORK_WIDTH-1:0];
      accumulator <= dom ? '0 : RESULT_WIDTH'(1);
      step_index  <= '0;
      dom_err     <= dom;
      ovf         <= 1'b0;
    end
    if (cmd.mul_lo) begin
      quo <= PROD_WIDTH'(product);
      rem <= '0;
    end
    if (cmd.mul_hi) begin
      quo <= quo + (PROD_WIDTH'(product) << LO_WIDTH);
    end
    if (cmd.div_step) begin
      if (!trial[REM_WIDTH]) begin
        rem <= trial[REM_WIDTH-1:0];
        quo <= {quo[PROD_WIDTH-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[PROD_WIDTH-2:0], 1'b0};
      end
    end
    if (cmd.commit) begin
      // Saturate and stop once the quotient no longer fits
      if (|quo[PROD_WIDTH-1:RESULT_WIDTH]) begin
        accumulator <= '1;
        ovf         <= 1'b1;
      end else begin
        accumulator <= quo[RESULT_WIDTH-1:0];
        step_index  <= step_index + 1'b1;
      end
    end
  end

  assign status.loop_done    = ovf || (step_index == work_k);
  assign result.coefficient  = COEFF_WIDTH'(accumulator);
  assign result.domain_error = dom_err;
  assign result.overflow     = ovf;

endmodule

// ===== sv/binomial_coefficient_unit.sv =====
// Top level of the binomial coefficient unit: handshakes, controller and datapath.
//
// Each request carries signed n and k and returns one result: C(n,k) as an exact
// unsigned 64-bit value, or domain_error with a zero coefficient when n<0, k<0 or
// k>n. k is first folded to n-k when it exceeds n/2; the unit then starts from 1
// and for i = 0 .. k-1 multiplies by (n-i) and divides by (i+1), each quotient
// being exact. A quotient of 2^64 or more saturates the coefficient to all ones,
// sets overflow and ends the loop. One request is worked on at a time; in_stall is
// high from acceptance until the result is loaded into the output register, which
// then holds it under out_stall while the next request is already taken. The loop
// runs j times, where j is the folded k, or fewer when overflow ends the loop
// early, at most about 34; a domain error or a zero column goes from the loop test
// straight to the finish state. Each iteration passes through the loop test, a low
// and a high pass on the shared 32 x 15 multiplier, the bit-serial restoring divider
// at one quotient bit per cycle over the 79-bit product, and the commit.
module binomial_coefficient_unit
  import bcu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  bcu_req_t    in_req,
  output logic        out_valid,
  input  logic        out_stall,
  output bcu_result_t out_result
);

  bcu_cmd_t    cmd;
  bcu_status_t status;
  bcu_result_t dp_result;
  logic        out_free;

  // The output register can take a new result when empty or being drained
  assign out_free = !out_valid || !out_stall;
  // Hold off new requests while one is in the loop or awaits the output register
  assign in_stall = !cmd.idle;

  bcu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .status   (status),
    .cmd      (cmd)
  );

  bcu_datapath u_datapath (
    .clk    (clk),
    .cmd    (cmd),
    .req    (in_req),
    .status (status),
    .result (dp_result)
  );

  // Output register: load on emit, drop valid once the result is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_result <= dp_result;
    end
  end

endmodule

// ===== tb/sv/binomial_coefficient_unit_tb.sv =====
// Self-checking testbench for binomial_coefficient_unit: directed and random requests.
`timescale 1ns / 100ps

module binomial_coefficient_unit_tb
  import bcu_pkg::*;
();

  // Clock, reset and both handshake channels. Give every block input a
  // known value from time zero.
  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  bcu_req_t    in_req = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  bcu_result_t out_result;

  // Results predicted for accepted requests, oldest first.
  bcu_result_t pending_coefficients[$];
  int          fail_count = 0;

  // Switches for random idling on the request and result sides.
  bit sender_gaps_on = 1'b1;
  bit receiver_stalls_on = 1'b1;
  int stall_left = 0;

  binomial_coefficient_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_result(out_result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Allow several times the worst-case time per request plus the longest
  // stalls, over the 210 requests of the run.
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Compute C(n,k) the way the unit does: fold k, then multiply by (n-i)
  // and divide by (i+1) with a wide intermediate. Stop at the first
  // quotient that no longer fits in the coefficient and saturate.
  function automatic bcu_result_t binomial_of(bcu_req_t req);
    int           n_idx;
    int           k_idx;
    int           i;
    logic [127:0] wide;
    logic [COEFF_WIDTH-1:0] acc;
    bcu_result_t  res;
    n_idx = int'($signed(req.n_value));
    k_idx = int'($signed(req.k_value));
    res = '0;
    if (n_idx < 0 || k_idx < 0 || k_idx > n_idx) begin
      res.domain_error = 1'b1;
      return res;
    end
    if (k_idx > n_idx / 2) begin
      k_idx = n_idx - k_idx;
    end
    acc = COEFF_WIDTH'(1);
    for (i = 0; i < k_idx && !res.overflow; i++) begin
      wide = ({64'b0, acc} * 128'(n_idx - i)) / 128'(i + 1);
      if (wide > {64'b0, {COEFF_WIDTH{1'b1}}}) begin
        res.overflow = 1'b1;
        acc = '1;
      end else begin
        acc = wide[COEFF_WIDTH-1:0];
      end
    end
    res.coefficient = acc;
    return res;
  endfunction

  // Print one line per mismatch and count it.
  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  // Pick the idle time after a request: mostly none or short, a few long.
  function automatic int pick_gap();
    int roll;
    if (!sender_gaps_on) begin
      return 0;
    end
    roll = $urandom_range(0, 19);
    if (roll < 10) begin
      return 0;
    end
    if (roll < 17) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 60);
  endfunction

  // Send one request. Entered and left just after a falling edge; valid
  // stays high across back-to-back requests so it is never dropped and
  // raised in the same step.
  task automatic issue_request(input logic signed [FIELD_WIDTH-1:0] n,
                               input logic signed [FIELD_WIDTH-1:0] k);
    bcu_req_t req;
    int       gap;
    req.n_value = n;
    req.k_value = k;
    in_req   <= req;
    in_valid <= 1'b1;
    // Hold the payload until the unit takes it.
    do begin
      @(posedge clk);
    end while (in_stall);
    pending_coefficients.push_back(binomial_of(req));
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Lower valid and hold off until every predicted result has come back.
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_coefficients.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Draw a request from a mix that reaches the loop, the fold, overflow
  // near the 64-bit edge and plain noise over the whole field range.
  task automatic issue_random_request();
    int n;
    int k;
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 3) begin
      // Raw noise: every bit of both fields, mostly domain errors.
      n = $urandom_range(0, 65535);
      k = $urandom_range(0, 65535);
    end else if (roll < 7) begin
      // Small rows: full loop runs, with k above n now and then.
      n = $urandom_range(0, 72);
      k = ($urandom_range(0, 9) == 0) ? n + $urandom_range(1, 3) : $urandom_range(0, n);
    end else if (roll == 7) begin
      // Large rows near either end of the row: short loops, fold taken at the far end.
      n = $urandom_range(0, 32767);
      k = $urandom_range(0, 6);
      if ($urandom_range(0, 1) == 1 && k <= n) begin
        k = n - k;
      end
    end else if (roll == 8) begin
      // Large rows anywhere: mostly early overflow.
      n = $urandom_range(0, 32767);
      k = $urandom_range(0, n);
    end else begin
      // Middle of rows around the 64-bit limit.
      n = $urandom_range(60, 70);
      k = n / 2 + $urandom_range(0, 2) - 1;
    end
    issue_request(FIELD_WIDTH'(n), FIELD_WIDTH'(k));
  endtask

  // Negative n or k, k above n: zero coefficient and the error flag.
  task automatic test_domain_errors();
    issue_request(-16'sd32768, 16'sd0);
    issue_request(16'sd5, -16'sd1);
    issue_request(16'sd3, 16'sd4);
    issue_request(-16'sd1, -16'sd1);
    issue_request(16'sd32766, 16'sd32767);
    issue_request(16'sd0, -16'sd32768);
  endtask

  // Zero column directly and after the fold, and the fold itself.
  task automatic test_zero_column_and_fold();
    issue_request(16'sd0, 16'sd0);
    issue_request(16'sd32767, 16'sd0);
    issue_request(16'sd32767, 16'sd32767);
    issue_request(16'sd5, 16'sd5);
    issue_request(16'sd10, 16'sd5);
    issue_request(16'sd10, 16'sd7);
    issue_request(16'sd32767, 16'sd1);
    issue_request(16'sd32767, 16'sd32766);
    issue_request(16'sd2, 16'sd1);
  endtask

  // Largest values that fit, overflow on the last step and overflow early.
  task automatic test_overflow_edges();
    issue_request(16'sd67, 16'sd33);
    issue_request(16'sd67, 16'sd34);
    issue_request(16'sd68, 16'sd34);
    issue_request(16'sd32767, 16'sd4);
    issue_request(16'sd32767, 16'sd5);
    issue_request(16'sd32767, 16'sd16383);
    issue_request(16'sd100, 16'sd50);
  endtask

  // Random requests with idling on both sides; pause halfway until the
  // unit and the result side are empty.
  task automatic test_random_requests(int count);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) begin
        wait_until_drained();
      end
      issue_random_request();
    end
  endtask

  // Back-to-back requests with the result side always ready.
  task automatic test_back_to_back(int count);
    sender_gaps_on = 1'b0;
    receiver_stalls_on = 1'b0;
    for (int i = 0; i < count; i++) begin
      issue_random_request();
    end
    sender_gaps_on = 1'b1;
    receiver_stalls_on = 1'b1;
  endtask

  // Drive the result-side stall at the falling edge: mostly ready, short
  // stalls now and then, a few long ones.
  always @(negedge clk) begin
    int roll;
    if (rst || !receiver_stalls_on) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      roll = $urandom_range(0, 39);
      if (roll < 5) begin
        stall_left = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else if (roll == 5) begin
        stall_left = $urandom_range(20, 200);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare every accepted result with the oldest prediction, field by field.
  always @(posedge clk) begin
    bcu_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_coefficients.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: coefficient %h",
                                  out_result.coefficient));
      end else begin
        want = pending_coefficients.pop_front();
        if (out_result.coefficient !== want.coefficient) begin
          report_mismatch($sformatf("coefficient %h, expected %h",
                                    out_result.coefficient, want.coefficient));
        end
        if (out_result.domain_error !== want.domain_error) begin
          report_mismatch($sformatf("domain_error %b, expected %b",
                                    out_result.domain_error, want.domain_error));
        end
        if (out_result.overflow !== want.overflow) begin
          report_mismatch($sformatf("overflow %b, expected %b",
                                    out_result.overflow, want.overflow));
        end
      end
    end
  end

  // Reset once, run the tests in turn, drain and give the verdict.
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_domain_errors();
    test_zero_column_and_fold();
    test_overflow_edges();
    test_random_requests(128);
    test_back_to_back(60);
    in_valid <= 1'b0;
    while (pending_coefficients.size() != 0) begin
      @(negedge clk);
    end
    // Watch on for stray results before giving the verdict.
    repeat (3000) @(negedge clk);
    if (pending_coefficients.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_coefficients.size()));
    end
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
